/* rtl/core/lrm_pkg.sv */
// Shared constants, register indexes and controller/datapath bundles
// for the largest-rectangle-in-mask block. No dependencies.
`timescale 1ns / 1ps

package lrm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int XS_W    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH_W = $clog2(MAX_WIDTH + 1);
  localparam int CFG_W   = 9;
  localparam int AREA_W  = 17;
  localparam int PROD_W  = HGT_W + XS_W;

  localparam logic CFG_MASK_WIDTH  = 1'b0;
  localparam logic CFG_MASK_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] MASK_WIDTH_RST  = CFG_W'(180);
  localparam logic [CFG_W-1:0] MASK_HEIGHT_RST = CFG_W'(120);

  typedef struct packed {
    logic capture;
    logic clear;
    logic load_cur;
    logic pop;
    logic update;
    logic push;
    logic to_sentinel;
    logic next_col;
    logic next_row;
    logic emit;
  } lrm_cmd_t;

  typedef struct packed {
    logic frame_start;
    logic pop_needed;
    logic last_col;
    logic last_row;
    logic sentinel;
    logic out_free;
  } lrm_stat_t;

endpackage

/* rtl/core/largest_rectangle_in_mask_top.sv */
// Top level of the largest-rectangle-in-mask block: joins lrm_ctrl and lrm_dp.
// Depends on lrm_pkg, lrm_ctrl, lrm_dp.
`timescale 1ns / 1ps

// Mask bits arrive one per beat in row-major order; frame_start marks the first
// bit of a frame. Each bit steps through accept, frame clear, column height
// read-modify-write and stack compare/push, plus, for every bar popped from
// the stack, an area multiply step and a step for the best-area compare and
// the registered read of the next stack entry. The last bit of each row adds
// a closing compare pass that pops every bar left on the stack the same way.
// Popped bars never exceed pushed bars. A new bit is not taken until the last
// one is through. The last bit of a frame then loads the result beat into the
// output register, and waits while the previous result beat has not been
// taken. Configuration writes are taken in any cycle and must be done while
// idle.
module largest_rectangle_in_mask_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       pixel_on,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 rect_x,
  output logic [7:0]                 rect_y,
  output logic [8:0]                 rect_w,
  output logic [8:0]                 rect_h,
  output logic [lrm_pkg::AREA_W-1:0] rect_area,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [lrm_pkg::CFG_W-1:0]  cfg_data
);

  lrm_pkg::lrm_cmd_t  cmd;
  lrm_pkg::lrm_stat_t stat;

  lrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_on    (pixel_on),
    .frame_start (frame_start),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .rect_area   (rect_area)
  );

endmodule

/* rtl/core/lrm_ctrl.sv */
// Sequencer for the mask rectangle search: steps each bit through
// height update, stack pops and push, and the result emit at frame end. Depends on lrm_pkg.
`timescale 1ns / 1ps

module lrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrm_pkg::lrm_stat_t stat,
  output lrm_pkg::lrm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_HGT  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clear  = stat.frame_start;
        state_next = S_HGT;
      end
      S_HGT: begin
        cmd.load_cur = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        if (stat.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = S_UPD;
        end else begin
          cmd.push = 1'b1;
          if (stat.sentinel) begin
            if (stat.last_row) begin
              state_next = S_EMIT;
            end else begin
              cmd.next_row = 1'b1;
              state_next   = S_IDLE;
            end
          end else if (!stat.last_col) begin
            cmd.next_col = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.to_sentinel = 1'b1;
            state_next      = S_CMP;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_CMP;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/lrm_dp.sv */
// Datapath for the mask rectangle search: config registers, column height
// memory, bar stack memory, area multiplier, best tracker and result register.
// Depends on lrm_pkg; driven by lrm_ctrl.
`timescale 1ns / 1ps

module lrm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  lrm_pkg::lrm_cmd_t            cmd,
  output lrm_pkg::lrm_stat_t           stat,
  input  logic                         pixel_on,
  input  logic                         frame_start,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [lrm_pkg::CFG_W-1:0]    cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   rect_x,
  output logic [7:0]                   rect_y,
  output logic [8:0]                   rect_w,
  output logic [8:0]                   rect_h,
  output logic [lrm_pkg::AREA_W-1:0]   rect_area
);

  localparam int COL_W   = lrm_pkg::COL_W;
  localparam int ROW_W   = lrm_pkg::ROW_W;
  localparam int HGT_W   = lrm_pkg::HGT_W;
  localparam int XS_W    = lrm_pkg::XS_W;
  localparam int DEPTH_W = lrm_pkg::DEPTH_W;
  localparam int CFG_W   = lrm_pkg::CFG_W;
  localparam int AREA_W  = lrm_pkg::AREA_W;
  localparam int PROD_W  = lrm_pkg::PROD_W;
  localparam int NCOL    = lrm_pkg::MAX_WIDTH;
  localparam int ENT_W   = COL_W + HGT_W;

  localparam logic [CFG_W-1:0] W_MAX = CFG_W'(lrm_pkg::MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_MAX = CFG_W'(lrm_pkg::MAX_HEIGHT);
  localparam logic [HGT_W-1:0] H_SAT = HGT_W'(lrm_pkg::MAX_HEIGHT);

  logic [CFG_W-1:0] mask_width, mask_height;
  logic [CFG_W-1:0] w_eff, h_eff;

  logic pix, fs;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  logic [HGT_W-1:0] hmem [NCOL];
  logic [HGT_W-1:0] hmem_q;
  logic [NCOL-1:0]  hvalid;
  logic [HGT_W-1:0] base_h, cur_calc;

  logic [HGT_W-1:0] cur;
  logic [XS_W-1:0]  xs;
  logic [COL_W-1:0] start;
  logic             sentinel;

  logic [ENT_W-1:0]   smem [NCOL];
  logic [ENT_W-1:0]   smem_q;
  logic [DEPTH_W-1:0] depth, depth_m2;
  logic [COL_W-1:0]   top_s;
  logic [HGT_W-1:0]   top_h;
  logic               push_ok;

  logic [XS_W-1:0]   wd;
  logic [PROD_W-1:0] prod;
  logic [AREA_W-1:0] area_q;
  logic [XS_W-1:0]   wd_q;
  logic [COL_W-1:0]  bs_q;
  logic [HGT_W-1:0]  bh_q;
  logic [ROW_W:0]    y_top;

  logic [7:0]        best_x, best_y;
  logic [8:0]        best_w, best_h;
  logic [AREA_W-1:0] best_area;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width  <= lrm_pkg::MASK_WIDTH_RST;
      mask_height <= lrm_pkg::MASK_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lrm_pkg::CFG_MASK_WIDTH:  mask_width  <= cfg_data;
        lrm_pkg::CFG_MASK_HEIGHT: mask_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    priority if (mask_width == '0) w_eff = CFG_W'(1);
    else if (mask_width > W_MAX)   w_eff = W_MAX;
    else                           w_eff = mask_width;
    priority if (mask_height == '0) h_eff = CFG_W'(1);
    else if (mask_height > H_MAX)   h_eff = H_MAX;
    else                            h_eff = mask_height;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= pixel_on;
      fs  <= frame_start;
    end
  end

  // column heights: registered read at the current column, valid bits clear per frame
  always_ff @(posedge clk) begin
    hmem_q <= hmem[col_count];
    if (cmd.load_cur) begin
      hmem[col_count] <= cur_calc;
    end
  end

  assign base_h   = hvalid[col_count] ? hmem_q : '0;
  assign cur_calc = !pix ? '0 : ((base_h < H_SAT) ? base_h + HGT_W'(1) : base_h);

  assign depth_m2 = depth - DEPTH_W'(2);
  assign wd       = xs - XS_W'(top_s);
  assign prod     = PROD_W'(top_h) * PROD_W'(wd);
  assign push_ok  = (cur != '0) && ((depth == '0) || (top_h < cur));
  assign y_top    = {1'b0, row_count} + (ROW_W+1)'(1) - (ROW_W+1)'(bh_q);

  // bar stack memory, top entry mirrored in registers
  always_ff @(posedge clk) begin
    smem_q <= smem[depth_m2[COL_W-1:0]];
    if (cmd.push && push_ok) begin
      smem[depth[COL_W-1:0]] <= {start, cur};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur      <= cur_calc;
      xs       <= XS_W'(col_count);
      start    <= col_count;
      sentinel <= 1'b0;
    end
    if (cmd.pop) begin
      area_q <= prod[AREA_W-1:0];
      wd_q   <= wd;
      bs_q   <= top_s;
      bh_q   <= top_h;
      start  <= top_s;
    end
    if (cmd.update) begin
      top_s <= smem_q[ENT_W-1:HGT_W];
      top_h <= smem_q[HGT_W-1:0];
    end
    if (cmd.push && push_ok) begin
      top_s <= start;
      top_h <= cur;
    end
    if (cmd.to_sentinel) begin
      cur      <= '0;
      xs       <= XS_W'(col_count) + XS_W'(1);
      sentinel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.emit) begin
      hvalid    <= '0;
      depth     <= '0;
      col_count <= '0;
      row_count <= '0;
      best_x    <= '0;
      best_y    <= '0;
      best_w    <= '0;
      best_h    <= '0;
      best_area <= '0;
    end else begin
      if (cmd.load_cur) begin
        hvalid[col_count] <= 1'b1;
      end
      if (cmd.pop) begin
        depth <= depth - DEPTH_W'(1);
      end
      if (cmd.push && push_ok) begin
        depth <= depth + DEPTH_W'(1);
      end
      if (cmd.update && (area_q > best_area)) begin
        best_area <= area_q;
        best_x    <= bs_q;
        best_y    <= y_top[ROW_W-1:0];
        best_w    <= wd_q;
        best_h    <= bh_q;
      end
      if (cmd.next_col) begin
        col_count <= col_count + COL_W'(1);
      end
      if (cmd.next_row) begin
        depth     <= '0;
        col_count <= '0;
        row_count <= row_count + ROW_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rect_x    <= best_x;
      rect_y    <= best_y;
      rect_w    <= best_w;
      rect_h    <= best_h;
      rect_area <= best_area;
    end
  end

  assign stat.frame_start = fs;
  assign stat.pop_needed  = (depth != '0) && (top_h > cur);
  assign stat.last_col    = (CFG_W'(col_count) + CFG_W'(1)) >= w_eff;
  assign stat.last_row    = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;
  assign stat.sentinel    = sentinel;
  assign stat.out_free    = !out_valid || !out_stall;

endmodule
